// File: hw/rtl/sorted_key_table_core_assert.svh
// Assertion macros for the sorted key table; empty when SYNTH is defined.
`ifndef SORTED_KEY_TABLE_CORE_ASSERT_SVH
`define SORTED_KEY_TABLE_CORE_ASSERT_SVH

`ifndef SYNTH
`define SKT_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("sorted key table assertion failed");
`define SKT_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sorted key table assertion failed");
`else
`define SKT_ASSERT(lbl, prop)
`define SKT_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

// File: hw/rtl/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg
// Shared constants, codes and the cell control bundle of the sorted key table.
// ----------------------------------------------------------------------------
`default_nettype none

package skt_pkg;

   localparam int DEF_CAPACITY = 1024;
   localparam int KEY_W        = 32;
   localparam int SPAN_W       = 31;
   localparam int TYPE_W       = 3;
   localparam int STATUS_W     = 2;

   // request types
   localparam logic [TYPE_W-1:0] REQ_LOWER  = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_EXACT  = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_INSERT = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_DELETE = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_ROTATE = 3'd4;
   localparam logic [TYPE_W-1:0] REQ_REPEAT = 3'd5;

   // result status
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOTF  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_ZERO  = 2'd3;

   // cell commands
   localparam logic [2:0] CELL_HOLD = 3'd0;
   localparam logic [2:0] CELL_CMP  = 3'd1;
   localparam logic [2:0] CELL_INS  = 3'd2;
   localparam logic [2:0] CELL_DEL  = 3'd3;
   localparam logic [2:0] CELL_ADD  = 3'd4;
   localparam logic [2:0] CELL_ROT  = 3'd5;

   typedef struct packed {
      logic [2:0]       cmd;
      logic [KEY_W-1:0] key;
      logic [KEY_W-1:0] add_lo;
      logic [KEY_W-1:0] add_hi;
   } cell_ctl_type;

endpackage

`default_nettype wire

// File: hw/rtl/sorted_key_table_core.sv
// ----------------------------------------------------------------------------
// sorted_key_table_core
// Ascending table of signed keys: search, insert, delete, rotate and repeat.
// ----------------------------------------------------------------------------
// Keys live one per cell in a row of CAPACITY cells, in logical order. One
// request is worked on at a time; its result sits in an output register, so
// the next request is taken while a result waits. A lower-bound search
// compares all cells at once, halves the range step by step until it sees
// the range close, then evaluates and writes the output register. Insert
// and delete add one shift of the row; an append skips the search. Rotate
// runs the divider, one search, an add across the row and then turns the
// row one position at a time. Repeat runs the divider, two searches, a
// product and a room check, then appends keys while the window turns,
// running on to the end of a whole period.
`default_nettype none

`include "sorted_key_table_core_assert.svh"

module sorted_key_table_core #(
   parameter int CAPACITY = skt_pkg::DEF_CAPACITY,
   localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [skt_pkg::TYPE_W-1:0]        req_type,
   input  wire logic signed [skt_pkg::KEY_W-1:0]  req_key_value,
   input  wire logic [skt_pkg::SPAN_W-1:0]        req_span_value,
   input  wire logic                              req_insert_at_end,
   input  wire logic                              req_want_less,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic signed [CNT_W:0]                  rsp_result_index,
   output logic [skt_pkg::STATUS_W-1:0]           rsp_status,
   output logic [CNT_W-1:0]                       rsp_entry_count
);
   import skt_pkg::*;

   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int PROD_W = CNT_W + SPAN_W;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_CMP  = 4'd1;
   localparam logic [3:0] S_SRCH = 4'd2;
   localparam logic [3:0] S_EVAL = 4'd3;
   localparam logic [3:0] S_INS  = 4'd4;
   localparam logic [3:0] S_DEL  = 4'd5;
   localparam logic [3:0] S_DIV  = 4'd6;
   localparam logic [3:0] S_ADD  = 4'd7;
   localparam logic [3:0] S_ROT  = 4'd8;
   localparam logic [3:0] S_MUL  = 4'd9;
   localparam logic [3:0] S_CHK  = 4'd10;
   localparam logic [3:0] S_FILL = 4'd11;
   localparam logic [3:0] S_DONE = 4'd12;

   localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

   logic [3:0]          state_ff, state_in;
   logic [TYPE_W-1:0]   op_ff, op_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [SPAN_W-1:0]   span_ff, span_in;
   logic                less_ff, less_in, second_ff, second_in;
   logic [KEY_W-1:0]    skey_ff, skey_in;
   logic [CNT_W-1:0]    lo_ff, lo_in, hi_ff, hi_in, lb_ff, lb_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic signed [CNT_W:0] ridx_ff, ridx_in;
   logic [STATUS_W-1:0] rst_ff, rst_in;
   logic [KEY_W-1:0]    alo_ff, alo_in, ahi_ff, ahi_in;
   logic [CNT_W-1:0]    steps_ff, steps_in;
   logic [SPAN_W-1:0]   n_ff, n_in;
   logic [CNT_W-1:0]    iend_ff, iend_in, oldn_ff, oldn_in, newn_ff, newn_in;
   logic [CNT_W-1:0]    wptr_ff, wptr_in, phase_ff, phase_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic                rvalid_ff, rvalid_in;
   logic signed [CNT_W:0] oidx_ff, oidx_in;
   logic [STATUS_W-1:0] ost_ff, ost_in;
   logic [CNT_W-1:0]    ocnt_ff, ocnt_in;

   cell_ctl_type        ctl;
   logic [CNT_W-1:0]    pos_a, pos_b;
   logic [CAPACITY-1:0] lt_vec, eq_vec;

   logic                div_start, div_busy, div_done;
   logic [KEY_W-1:0]    div_a, div_b, div_q, div_r;

   logic [CNT_W:0]      mid_sum;
   logic [CNT_W-1:0]    mid;
   logic [KEY_W-1:0]    len32, sprime, cut, abs_key;
   logic [PROD_W:0]     newn_sum;
   logic                accept, found;

   skt_cell_row #(.CAPACITY(CAPACITY), .CNT_W(CNT_W)) u_row (
      .clock  (clock),
      .ctl    (ctl),
      .pos_a  (pos_a),
      .pos_b  (pos_b),
      .lt_vec (lt_vec),
      .eq_vec (eq_vec)
   );

   skt_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_a),
      .divisor   (div_b),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   assign req_ready = state_ff == S_IDLE;
   assign accept    = req_valid && req_ready;
   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid       = mid_sum[CNT_W:1];
   assign found     = (lb_ff < count_ff) && eq_vec[lb_ff[IDX_W-1:0]];
   assign len32     = {1'b0, span_ff};
   assign sprime    = key_ff[KEY_W-1] ? len32 - div_r : div_r;
   assign cut       = key_ff[KEY_W-1] ? div_r : len32 - div_r;
   assign abs_key   = req_key_value[KEY_W-1] ? KEY_W'(-req_key_value) : req_key_value;
   assign newn_sum  = {1'b0, prod_ff} + (PROD_W+1)'(iend_ff);

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      key_in    = key_ff;
      span_in   = span_ff;
      less_in   = less_ff;
      second_in = second_ff;
      skey_in   = skey_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      lb_in     = lb_ff;
      count_in  = count_ff;
      ridx_in   = ridx_ff;
      rst_in    = rst_ff;
      alo_in    = alo_ff;
      ahi_in    = ahi_ff;
      steps_in  = steps_ff;
      n_in      = n_ff;
      iend_in   = iend_ff;
      oldn_in   = oldn_ff;
      newn_in   = newn_ff;
      wptr_in   = wptr_ff;
      phase_in  = phase_ff;
      prod_in   = prod_ff;
      rvalid_in = rvalid_ff;
      oidx_in   = oidx_ff;
      ost_in    = ost_ff;
      ocnt_in   = ocnt_ff;
      ctl       = '{cmd: CELL_HOLD, key: skey_ff, add_lo: alo_ff, add_hi: ahi_ff};
      pos_a     = lb_ff;
      pos_b     = count_ff - CNT_W'(1);
      div_start = 1'b0;
      div_a     = abs_key;
      div_b     = {1'b0, req_span_value};

      if (rvalid_ff && rsp_ready) begin
         rvalid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in     = req_type;
               key_in    = req_key_value;
               span_in   = req_span_value;
               less_in   = req_want_less;
               second_in = 1'b0;
               skey_in   = req_key_value;
               lo_in     = '0;
               hi_in     = count_ff;
               ridx_in   = '1;
               rst_in    = ST_OK;
               state_in  = S_DONE;
               case (req_type)
                  REQ_LOWER, REQ_EXACT, REQ_DELETE: begin
                     state_in = S_CMP;
                  end
                  REQ_INSERT: begin
                     if (count_ff == CAP_C) begin
                        rst_in = ST_FULL;
                     end else if (req_insert_at_end) begin
                        lb_in    = count_ff;
                        state_in = S_INS;
                     end else begin
                        state_in = S_CMP;
                     end
                  end
                  REQ_ROTATE: begin
                     if (req_span_value == '0) begin
                        rst_in = ST_ZERO;
                     end else if (count_ff == '0) begin
                        ridx_in = '0;
                     end else begin
                        div_start = 1'b1;
                        state_in  = S_DIV;
                     end
                  end
                  REQ_REPEAT: begin
                     div_a = {1'b0, req_span_value};
                     div_b = req_key_value;
                     if (req_key_value == '0) begin
                        rst_in = ST_ZERO;
                     end else begin
                        div_start = 1'b1;
                        state_in  = S_DIV;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_CMP: begin
            ctl.cmd  = CELL_CMP;
            state_in = S_SRCH;
         end
         S_SRCH: begin
            if (lo_ff == hi_ff) begin
               lb_in    = lo_ff;
               state_in = S_EVAL;
            end else if (lt_vec[mid[IDX_W-1:0]]) begin
               lo_in = mid + CNT_W'(1);
            end else begin
               hi_in = mid;
            end
         end
         S_EVAL: begin
            state_in = S_DONE;
            case (op_ff)
               REQ_LOWER: begin
                  ridx_in = $signed({1'b0, lb_ff}) - $signed((CNT_W+1)'(less_ff));
               end
               REQ_EXACT: begin
                  if (found) begin
                     ridx_in = {1'b0, lb_ff};
                  end else begin
                     rst_in = ST_NOTF;
                  end
               end
               REQ_INSERT: begin
                  state_in = S_INS;
               end
               REQ_DELETE: begin
                  if (found) begin
                     state_in = S_DEL;
                  end else begin
                     rst_in = ST_NOTF;
                  end
               end
               REQ_ROTATE: begin
                  state_in = S_ADD;
               end
               REQ_REPEAT: begin
                  if (!second_ff) begin
                     // first pass found the cut for the remainder, now the wrap point
                     iend_in   = lb_ff;
                     second_in = 1'b1;
                     skey_in   = key_ff;
                     lo_in     = '0;
                     hi_in     = count_ff;
                     state_in  = S_CMP;
                  end else begin
                     oldn_in  = lb_ff;
                     state_in = S_MUL;
                  end
               end
               default: begin
               end
            endcase
         end
         S_INS: begin
            ctl.cmd  = CELL_INS;
            ctl.key  = key_ff;
            count_in = count_ff + CNT_W'(1);
            ridx_in  = {1'b0, lb_ff};
            state_in = S_DONE;
         end
         S_DEL: begin
            ctl.cmd  = CELL_DEL;
            count_in = count_ff - CNT_W'(1);
            ridx_in  = {1'b0, lb_ff};
            state_in = S_DONE;
         end
         S_DIV: begin
            if (div_done) begin
               lo_in = '0;
               hi_in = count_ff;
               if (op_ff == REQ_ROTATE) begin
                  if (div_r == '0) begin
                     ridx_in  = '0;
                     state_in = S_DONE;
                  end else begin
                     alo_in   = sprime;
                     ahi_in   = sprime - len32;
                     skey_in  = cut;
                     state_in = S_CMP;
                  end
               end else begin
                  n_in     = div_q[SPAN_W-1:0];
                  skey_in  = div_r;
                  state_in = S_CMP;
               end
            end
         end
         S_ADD: begin
            ctl.cmd  = CELL_ADD;
            steps_in = lb_ff;
            ridx_in  = '0;
            if (lb_ff != '0 && lb_ff < count_ff) begin
               state_in = S_ROT;
            end else begin
               state_in = S_DONE;
            end
         end
         S_ROT: begin
            ctl.cmd  = CELL_ROT;
            pos_a    = CAP_C;
            steps_in = steps_ff - CNT_W'(1);
            if (steps_ff == CNT_W'(1)) begin
               state_in = S_DONE;
            end
         end
         S_MUL: begin
            prod_in  = {{SPAN_W{1'b0}}, oldn_ff} * {{CNT_W{1'b0}}, n_ff};
            state_in = S_CHK;
         end
         S_CHK: begin
            if (newn_sum > (PROD_W+1)'(CAPACITY)) begin
               rst_in   = ST_FULL;
               state_in = S_DONE;
            end else begin
               count_in = newn_sum[CNT_W-1:0];
               newn_in  = newn_sum[CNT_W-1:0];
               ridx_in  = '0;
               wptr_in  = oldn_ff;
               phase_in = '0;
               alo_in   = key_ff;
               if (n_ff != '0 && oldn_ff != '0 && newn_sum[CNT_W-1:0] > oldn_ff) begin
                  state_in = S_FILL;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_FILL: begin
            // window of the first oldn keys turns once per cycle; its head,
            // plus the period offset, lands at the write pointer
            ctl.cmd = CELL_ROT;
            pos_a   = (wptr_ff < newn_ff) ? wptr_ff : CAP_C;
            pos_b   = oldn_ff - CNT_W'(1);
            if (wptr_ff < newn_ff) begin
               wptr_in = wptr_ff + CNT_W'(1);
            end
            if (phase_ff == oldn_ff - CNT_W'(1)) begin
               phase_in = '0;
               alo_in   = alo_ff + key_ff;
               if ({1'b0, wptr_ff} + (CNT_W+1)'(1) >= {1'b0, newn_ff}) begin
                  state_in = S_DONE;
               end
            end else begin
               phase_in = phase_ff + CNT_W'(1);
            end
         end
         S_DONE: begin
            if (!rvalid_ff || rsp_ready) begin
               rvalid_in = 1'b1;
               oidx_in   = ridx_ff;
               ost_in    = rst_ff;
               ocnt_in   = count_ff;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rvalid_ff <= rvalid_in;
      end
      op_ff     <= op_in;
      key_ff    <= key_in;
      span_ff   <= span_in;
      less_ff   <= less_in;
      second_ff <= second_in;
      skey_ff   <= skey_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      lb_ff     <= lb_in;
      ridx_ff   <= ridx_in;
      rst_ff    <= rst_in;
      alo_ff    <= alo_in;
      ahi_ff    <= ahi_in;
      steps_ff  <= steps_in;
      n_ff      <= n_in;
      iend_ff   <= iend_in;
      oldn_ff   <= oldn_in;
      newn_ff   <= newn_in;
      wptr_ff   <= wptr_in;
      phase_ff  <= phase_in;
      prod_ff   <= prod_in;
      oidx_ff   <= oidx_in;
      ost_ff    <= ost_in;
      ocnt_ff   <= ocnt_in;
   end

   assign rsp_valid        = rvalid_ff;
   assign rsp_result_index = oidx_ff;
   assign rsp_status       = ost_ff;
   assign rsp_entry_count  = ocnt_ff;

   `SKT_ASSERT(a_count_range, count_ff <= CAP_C)
   `SKT_ASSERT_IMP(a_search_order, state_ff == S_SRCH, lo_ff <= hi_ff)
   `SKT_ASSERT_IMP(a_insert_room, state_ff == S_INS, count_ff < CAP_C)
   `SKT_ASSERT_IMP(a_div_running, state_ff == S_DIV, div_busy || div_done)
   `SKT_ASSERT_IMP(a_idle_div, state_ff == S_IDLE, !div_busy)

endmodule

`default_nettype wire

// File: hw/rtl/skt_cell.sv
// ----------------------------------------------------------------------------
// skt_cell
// One table slot: holds a key, compares it, shifts, adds and rotates.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_cell #(
   parameter int CNT_W = 11
) (
   input  wire logic                      clock,
   input  wire skt_pkg::cell_ctl_type     ctl,
   input  wire logic [CNT_W-1:0]          idx,
   input  wire logic [CNT_W-1:0]          pos_a,
   input  wire logic [CNT_W-1:0]          pos_b,
   input  wire logic [skt_pkg::KEY_W-1:0] left_key,
   input  wire logic [skt_pkg::KEY_W-1:0] right_key,
   input  wire logic [skt_pkg::KEY_W-1:0] head_key,
   output logic [skt_pkg::KEY_W-1:0]      key_out,
   output logic                           lt_out,
   output logic                           eq_out
);
   import skt_pkg::*;

   logic [KEY_W-1:0] key_ff, key_in;
   logic             lt_ff, lt_in, eq_ff, eq_in;

   always_comb begin
      key_in = key_ff;
      lt_in  = lt_ff;
      eq_in  = eq_ff;
      case (ctl.cmd)
         CELL_CMP: begin
            lt_in = $signed(key_ff) < $signed(ctl.key);
            eq_in = key_ff == ctl.key;
         end
         CELL_INS: begin
            if (idx == pos_a) begin
               key_in = ctl.key;
            end else if (idx > pos_a) begin
               key_in = left_key;
            end
         end
         CELL_DEL: begin
            if (idx >= pos_a) begin
               key_in = right_key;
            end
         end
         CELL_ADD: begin
            key_in = key_ff + ((idx < pos_a) ? ctl.add_lo : ctl.add_hi);
         end
         CELL_ROT: begin
            // window [0, pos_b] turns left by one; pos_a takes head plus offset
            if (idx == pos_a) begin
               key_in = head_key + ctl.add_lo;
            end else if (idx < pos_b) begin
               key_in = right_key;
            end else if (idx == pos_b) begin
               key_in = head_key;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      lt_ff  <= lt_in;
      eq_ff  <= eq_in;
   end

   assign key_out = key_ff;
   assign lt_out  = lt_ff;
   assign eq_out  = eq_ff;

endmodule

`default_nettype wire

// File: hw/rtl/skt_cell_row.sv
// ----------------------------------------------------------------------------
// skt_cell_row
// The row of key cells, each wired to its neighbors and to the head cell.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_cell_row #(
   parameter int CAPACITY = 1024,
   parameter int CNT_W    = 11
) (
   input  wire logic                      clock,
   input  wire skt_pkg::cell_ctl_type     ctl,
   input  wire logic [CNT_W-1:0]          pos_a,
   input  wire logic [CNT_W-1:0]          pos_b,
   output logic [CAPACITY-1:0]            lt_vec,
   output logic [CAPACITY-1:0]            eq_vec
);
   import skt_pkg::*;

   logic [KEY_W-1:0] keys [CAPACITY];

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [KEY_W-1:0] left_key, right_key;
      if (g == 0) begin : g_first
         assign left_key = '0;
      end else begin : g_mid
         assign left_key = keys[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right_key = '0;
      end else begin : g_notlast
         assign right_key = keys[g+1];
      end
      skt_cell #(.CNT_W(CNT_W)) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .idx       (CNT_W'(g)),
         .pos_a     (pos_a),
         .pos_b     (pos_b),
         .left_key  (left_key),
         .right_key (right_key),
         .head_key  (keys[0]),
         .key_out   (keys[g]),
         .lt_out    (lt_vec[g]),
         .eq_out    (eq_vec[g])
      );
   end

endmodule

`default_nettype wire

// File: hw/rtl/skt_divider.sv
// ----------------------------------------------------------------------------
// skt_divider
// Unsigned 32-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_divider (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [skt_pkg::KEY_W-1:0] dividend,
   input  wire logic [skt_pkg::KEY_W-1:0] divisor,
   output logic                           busy,
   output logic                           done,
   output logic [skt_pkg::KEY_W-1:0]      quotient,
   output logic [skt_pkg::KEY_W-1:0]      remainder
);
   import skt_pkg::*;

   localparam int CW = $clog2(KEY_W + 1);

   logic [KEY_W-1:0] quo_ff, quo_in, rem_ff, rem_in, div_ff, div_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [KEY_W:0]   shifted, trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[KEY_W-1]};
      trial   = shifted - {1'b0, div_ff};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = CW'(KEY_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[KEY_W]) begin
            rem_in = trial[KEY_W-1:0];
            quo_in = {quo_ff[KEY_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[KEY_W-1:0];
            quo_in = {quo_ff[KEY_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted key table: a directed table of requests,
// then weighted random requests under changing sender gaps and receiver
// back-pressure; each result is checked against a local model or set values.
// ----------------------------------------------------------------------------
module tb_top;
   import skt_pkg::*;

   localparam int  TABLE_SIZE  = 1024;
   localparam int  RANDOM_REQS = 1880;
   localparam int  CYCLE_LIMIT = 20_000_000;
   localparam logic [2:0] REQ_SPARE6 = 3'd6;
   localparam logic [2:0] REQ_SPARE7 = 3'd7;

   typedef struct {
      logic [2:0]         rtype;
      logic signed [31:0] key;
      logic [30:0]        span;
      logic               at_end;
      logic               less;
      bit                 typed;
      logic signed [11:0] idx;
      logic [1:0]         st;
      logic [10:0]        cnt;
   } request_row_type;

   typedef struct {
      logic signed [11:0] idx;
      logic [1:0]         st;
      logic [10:0]        cnt;
   } table_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [2:0] req_type = '0;
   logic signed [31:0] req_key_value = '0;
   logic [30:0] req_span_value = '0;
   logic req_insert_at_end = 1'b0;
   logic req_want_less = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [11:0] rsp_result_index;
   logic [1:0] rsp_status;
   logic [10:0] rsp_entry_count;

   // table model, kept in logical order
   logic signed [31:0] model_keys [TABLE_SIZE];
   logic signed [31:0] turn_buf [TABLE_SIZE];
   int unsigned model_count = 0;

   table_result_type pending_results[$];
   int errors = 0;
   int cycles = 0;
   int idle_pct = 0;
   int stall_pct = 0;

   sorted_key_table_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_type(req_type), .req_key_value(req_key_value),
      .req_span_value(req_span_value), .req_insert_at_end(req_insert_at_end),
      .req_want_less(req_want_less),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_result_index(rsp_result_index), .rsp_status(rsp_status),
      .rsp_entry_count(rsp_entry_count)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("sorted_key_table_core verification failed");
         $finish;
      end
   end

   function automatic int unsigned lower_bound(input logic signed [31:0] key);
      int unsigned lo, hi, mid;
      lo = 0;
      hi = model_count;
      while (lo != hi) begin
         mid = (lo + hi) >> 1;
         if (model_keys[mid] < key) lo = mid + 1;
         else hi = mid;
      end
      return lo;
   endfunction

   function automatic void rotate_keys(input logic signed [31:0] shift, input logic [30:0] span,
                                       output table_result_type r);
      longint len, s, cut;
      logic [63:0] lo_add, hi_add;
      int unsigned ci;
      len = longint'(span);
      s = longint'(shift);
      r.idx = 0;
      r.st = ST_OK;
      if (len == 0) begin
         r.idx = -1;
         r.st = ST_ZERO;
         return;
      end
      if (model_count == 0) return;
      if (s >= len) s = s % len;
      else if (s <= -len) s = -((-s) % len);
      if (s == 0) return;
      cut = -s;
      if (cut < 0) cut += len;
      if (s < 0) s += len;
      ci = lower_bound(cut[31:0]);
      lo_add = s;
      hi_add = s - len;
      for (int i = 0; i < model_count; i++)
         model_keys[i] = model_keys[i] + (i < ci ? lo_add[31:0] : hi_add[31:0]);
      if (ci == 0 || ci >= model_count) return;
      // keys from the cutoff on move to the front
      for (int i = 0; i < model_count; i++) turn_buf[i] = model_keys[(ci + i) % model_count];
      for (int i = 0; i < model_count; i++) model_keys[i] = turn_buf[i];
   endfunction

   function automatic void repeat_keys(input logic [31:0] wrap, input logic [30:0] span,
                                       output table_result_type r);
      logic [31:0] reps, rem_pos;
      int unsigned iend, oldn;
      longint grown;
      r.idx = -1;
      if (wrap == 0) begin
         r.st = ST_ZERO;
         return;
      end
      reps = {1'b0, span} / wrap;
      rem_pos = {1'b0, span} % wrap;
      iend = lower_bound(rem_pos);
      oldn = lower_bound(wrap);
      grown = longint'(oldn) * longint'(reps) + iend;
      if (grown > TABLE_SIZE) begin
         r.st = ST_FULL;
         return;
      end
      if (reps >= 1 && oldn > 0)
         for (int d = oldn; d < grown; d++)
            model_keys[d] = model_keys[d % oldn] + wrap * (d / oldn);
      model_count = grown;
      r.idx = 0;
      r.st = ST_OK;
   endfunction

   function automatic table_result_type apply_request(input request_row_type q);
      table_result_type r;
      int unsigned lb;
      r.idx = -1;
      r.st = ST_OK;
      case (q.rtype)
         REQ_LOWER: r.idx = lower_bound(q.key) - (q.less ? 1 : 0);
         REQ_EXACT: begin
            lb = lower_bound(q.key);
            if (lb < model_count && model_keys[lb] == q.key) r.idx = lb;
            else r.st = ST_NOTF;
         end
         REQ_INSERT: begin
            if (model_count >= TABLE_SIZE) r.st = ST_FULL;
            else begin
               lb = q.at_end ? model_count : lower_bound(q.key);
               for (int j = model_count; j > lb; j--) model_keys[j] = model_keys[j-1];
               model_keys[lb] = q.key;
               model_count++;
               r.idx = lb;
            end
         end
         REQ_DELETE: begin
            lb = lower_bound(q.key);
            if (lb < model_count && model_keys[lb] == q.key) begin
               for (int j = lb; j + 1 < model_count; j++) model_keys[j] = model_keys[j+1];
               model_count--;
               r.idx = lb;
            end else r.st = ST_NOTF;
         end
         REQ_ROTATE: rotate_keys(q.key, q.span, r);
         REQ_REPEAT: repeat_keys(q.key, q.span, r);
         default: ;
      endcase
      r.cnt = model_count;
      return r;
   endfunction

   task automatic send_request(input request_row_type q);
      table_result_type r;
      @(negedge clock);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_type = q.rtype;
      req_key_value = q.key;
      req_span_value = q.span;
      req_insert_at_end = q.at_end;
      req_want_less = q.less;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      r = apply_request(q);
      if (q.typed) begin
         r.idx = q.idx;
         r.st = q.st;
         r.cnt = q.cnt;
      end
      pending_results.push_back(r);
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch on %s at cycle %0d: got %0d, expected %0d", what, cycles, got, want);
      errors++;
   endtask

   always @(negedge clock)
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);

   always @(posedge clock) begin
      table_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", 1, 0);
         end else begin
            e = pending_results.pop_front();
            if (rsp_result_index !== e.idx) report_mismatch("index", rsp_result_index, e.idx);
            if (rsp_status !== e.st) report_mismatch("status", rsp_status, e.st);
            if (rsp_entry_count !== e.cnt) report_mismatch("count", rsp_entry_count, e.cnt);
         end
      end
   end

   function automatic request_row_type row(input logic [2:0] t, input logic [31:0] k,
                                           input logic [30:0] sp, input logic e, input logic l);
      request_row_type q;
      q.rtype = t; q.key = k; q.span = sp; q.at_end = e; q.less = l;
      q.typed = 0; q.idx = 0; q.st = ST_OK; q.cnt = 0;
      return q;
   endfunction

   function automatic request_row_type known(input request_row_type q, input int i,
                                             input logic [1:0] s, input int c);
      q.typed = 1; q.idx = i; q.st = s; q.cnt = c;
      return q;
   endfunction

   function automatic request_row_type random_request();
      int pick;
      request_row_type q;
      pick = $urandom_range(0, 99);
      q = row(REQ_LOWER, $urandom_range(0, 2000) - 1000, $urandom, $urandom_range(0, 9) == 0,
              $urandom_range(0, 1));
      if ($urandom_range(0, 4) == 0) q.key = $urandom;
      if (pick < 25) q.rtype = REQ_LOWER;
      else if (pick < 42) q.rtype = REQ_EXACT;
      else if (pick < 65) q.rtype = REQ_INSERT;
      else if (pick < 80) q.rtype = REQ_DELETE;
      else if (pick < 87) begin
         q.rtype = REQ_ROTATE;
         if ($urandom_range(0, 9) < 7) q.span = $urandom_range(0, 3000);
      end else if (pick < 95) begin
         q.rtype = REQ_REPEAT;
         if ($urandom_range(0, 9) < 7) q.key = $urandom_range(0, 300);
         if ($urandom_range(0, 9) < 8) q.span = $urandom_range(0, 40000);
      end else q.rtype = $urandom_range(0, 1) ? REQ_SPARE6 : REQ_SPARE7;
      return q;
   endfunction

   initial begin
      request_row_type directed[$];
      directed = '{
         known(row(REQ_LOWER, 32'sd5, 0, 0, 0), 0, ST_OK, 0),
         known(row(REQ_LOWER, 32'sd5, 0, 0, 1), -1, ST_OK, 0),
         known(row(REQ_EXACT, 32'sd5, 0, 0, 0), -1, ST_NOTF, 0),
         known(row(REQ_DELETE, 32'sd5, 0, 0, 0), -1, ST_NOTF, 0),
         known(row(REQ_ROTATE, 32'sd3, 0, 0, 0), -1, ST_ZERO, 0),
         known(row(REQ_REPEAT, 32'sd0, 31'd9, 0, 0), -1, ST_ZERO, 0),
         known(row(REQ_ROTATE, 32'sd3, 31'd5, 0, 0), 0, ST_OK, 0),
         known(row(REQ_INSERT, 32'h7fffffff, 0, 0, 0), 0, ST_OK, 1),
         known(row(REQ_INSERT, 32'h80000000, 0, 0, 0), 0, ST_OK, 2),
         known(row(REQ_INSERT, 32'sd0, 31'h7fffffff, 0, 1), 1, ST_OK, 3),
         known(row(REQ_EXACT, 32'sd0, 0, 1, 1), 1, ST_OK, 3),
         known(row(REQ_SPARE6, 32'sd0, 0, 0, 0), -1, ST_OK, 3),
         known(row(REQ_SPARE7, 32'hffffffff, 31'h7fffffff, 1, 1), -1, ST_OK, 3),
         row(REQ_LOWER, 32'h80000000, 0, 0, 1),
         row(REQ_INSERT, 32'sd7, 0, 1, 0),
         row(REQ_INSERT, 32'sd3, 0, 0, 0),
         row(REQ_ROTATE, -32'sd3, 31'd10, 0, 0),
         row(REQ_ROTATE, 32'h7fffffff, 31'h7fffffff, 0, 0),
         row(REQ_ROTATE, 32'h80000000, 31'd17, 0, 0),
         row(REQ_DELETE, 32'h7fffffff, 0, 0, 0),
         row(REQ_REPEAT, 32'hfffffff0, 31'd100, 0, 0),
         row(REQ_REPEAT, 32'sd4, 31'd20, 0, 0),
         row(REQ_REPEAT, 32'sd1, 31'h7fffffff, 0, 0),
         row(REQ_REPEAT, 32'sd3, 31'd3000, 0, 0),
         row(REQ_INSERT, 32'sd1, 0, 0, 0)
      };
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (directed[i]) send_request(directed[i]);
      for (int n = 0; n < RANDOM_REQS; n++) begin
         case ((n / 100) % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 88; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 88; end
            default: begin idle_pct = 25; stall_pct = 25; end
         endcase
         send_request(random_request());
      end
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (2500) @(posedge clock);
      if (errors == 0) $display("sorted_key_table_core verification clean");
      else $display("sorted_key_table_core verification failed");
      $finish;
   end

endmodule
